FILE: src/nwl_pkg.sv
package nwl_pkg;

  localparam int POS_W  = 24;
  localparam int QUAT_W = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int LA_W   = 8;
  localparam int IDX_OUT_W = 8;

  localparam logic [LA_W-1:0] LOOKAHEAD_RST = 8'd5;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } in_req_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_OUT_W-1:0]     nearest_index;
    logic [IDX_OUT_W-1:0]     goal_index;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [QUAT_W-1:0] goal_qx;
    logic signed [QUAT_W-1:0] goal_qy;
    logic signed [QUAT_W-1:0] goal_qz;
    logic signed [QUAT_W-1:0] goal_qw;
  } out_rsp_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [QUAT_W-1:0] qx;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qz;
    logic signed [QUAT_W-1:0] qw;
  } wp_t;

  // travels alongside each entry through the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_GOAL,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

FILE: src/nearest_waypoint_lookahead.sv
// channel   ports                                 transfer
// -------   -----------------------------------   ---------------------------------
// input     start, busy, in_data                  start & !busy
// result    out_valid, out_data                   out_valid (one cycle, no backpressure)
// config    cfg_valid, cfg_ready, cfg_data        cfg_valid & cfg_ready
//
// A load leaves busy low. A query on a non-empty table keeps busy high while it
// works and then strobes out_valid: one table read per cycle through the single
// read port, then a 3-stage distance pipeline, goal clamp and goal read. An
// empty-table query answers next cycle.
// Reset clears the entry count and sets lookahead to 5; table contents are not cleared.
// Results cannot be stalled.
module nearest_waypoint_lookahead #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  nwl_pkg::in_req_t             in_data,
  output logic                         out_valid,
  output nwl_pkg::out_rsp_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nwl_pkg::LA_W-1:0]     cfg_data
);

  localparam int IW = $clog2(MAX_WAYPOINTS);

  logic [nwl_pkg::LA_W-1:0]          lookahead_r, lookahead_nxt;
  logic                              wr_en, rd_en;
  logic [IW-1:0]                     wr_addr, rd_addr, rd_idx, dist_idx;
  nwl_pkg::wp_t                      wr_data, rd_data;
  nwl_pkg::scan_tag_t                rd_tag, dist_tag;
  logic signed [nwl_pkg::POS_W-1:0]  rob_x, rob_y;
  logic [nwl_pkg::DIST_W-1:0]        dist_val;

  assign cfg_ready     = !busy;
  assign lookahead_nxt = (cfg_valid && cfg_ready) ? cfg_data : lookahead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookahead_r <= nwl_pkg::LOOKAHEAD_RST;
    end else begin
      lookahead_r <= lookahead_nxt;
    end
  end

  nwl_store #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nwl_dist #(
    .IW(IW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (rd_tag),
    .idx_in   (rd_idx),
    .wp_x     (rd_data.x),
    .wp_y     (rd_data.y),
    .rob_x    (rob_x),
    .rob_y    (rob_y),
    .tag_out  (dist_tag),
    .idx_out  (dist_idx),
    .dist_out (dist_val)
  );

  nwl_ctrl #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .lookahead (lookahead_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rd_tag    (rd_tag),
    .rd_idx    (rd_idx),
    .rob_x     (rob_x),
    .rob_y     (rob_y),
    .dist_tag  (dist_tag),
    .dist_idx  (dist_idx),
    .dist_val  (dist_val),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: src/nwl_store.sv
module nwl_store #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(MAX_WAYPOINTS)-1:0] wr_addr,
  input  nwl_pkg::wp_t                     wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(MAX_WAYPOINTS)-1:0] rd_addr,
  output nwl_pkg::wp_t                     rd_data
);

  nwl_pkg::wp_t mem [MAX_WAYPOINTS];
  nwl_pkg::wp_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/nwl_dist.sv
module nwl_dist #(
  parameter int IW = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  nwl_pkg::scan_tag_t                     tag_in,
  input  logic [IW-1:0]                          idx_in,
  input  logic signed [nwl_pkg::POS_W-1:0]       wp_x,
  input  logic signed [nwl_pkg::POS_W-1:0]       wp_y,
  input  logic signed [nwl_pkg::POS_W-1:0]       rob_x,
  input  logic signed [nwl_pkg::POS_W-1:0]       rob_y,
  output nwl_pkg::scan_tag_t                     tag_out,
  output logic [IW-1:0]                          idx_out,
  output logic [nwl_pkg::DIST_W-1:0]             dist_out
);

  // stage 1: differences, stage 2: squares, stage 3: sum
  logic signed [nwl_pkg::DIFF_W-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [2*nwl_pkg::DIFF_W-1:0] px, py;
  logic [nwl_pkg::SQ_W-1:0]            sqx_r, sqy_r;
  logic [nwl_pkg::DIST_W-1:0]          sum_r, sum_nxt;
  nwl_pkg::scan_tag_t                  tag1_r, tag2_r, tag3_r;
  logic [IW-1:0]                       idx1_r, idx2_r, idx3_r;

  always_comb begin
    dx_nxt  = nwl_pkg::DIFF_W'(wp_x) - nwl_pkg::DIFF_W'(rob_x);
    dy_nxt  = nwl_pkg::DIFF_W'(wp_y) - nwl_pkg::DIFF_W'(rob_y);
    px      = dx_r * dx_r;
    py      = dy_r * dy_r;
    sum_nxt = nwl_pkg::DIST_W'(sqx_r) + nwl_pkg::DIST_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  // |diff| < 2^24, so the square fits in 48 bits
  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    idx1_r <= idx_in;
    sqx_r  <= px[nwl_pkg::SQ_W-1:0];
    sqy_r  <= py[nwl_pkg::SQ_W-1:0];
    idx2_r <= idx1_r;
    sum_r  <= sum_nxt;
    idx3_r <= idx2_r;
  end

  assign tag_out  = tag3_r;
  assign idx_out  = idx3_r;
  assign dist_out = sum_r;

endmodule

FILE: src/nwl_ctrl.sv
module nwl_ctrl #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  nwl_pkg::in_req_t                 in_data,
  output logic                             busy,
  input  logic [nwl_pkg::LA_W-1:0]         lookahead,
  output logic                             wr_en,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] wr_addr,
  output nwl_pkg::wp_t                     wr_data,
  output logic                             rd_en,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] rd_addr,
  input  nwl_pkg::wp_t                     rd_data,
  output nwl_pkg::scan_tag_t               rd_tag,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] rd_idx,
  output logic signed [nwl_pkg::POS_W-1:0] rob_x,
  output logic signed [nwl_pkg::POS_W-1:0] rob_y,
  input  nwl_pkg::scan_tag_t               dist_tag,
  input  logic [$clog2(MAX_WAYPOINTS)-1:0] dist_idx,
  input  logic [nwl_pkg::DIST_W-1:0]       dist_val,
  output logic                             out_valid,
  output nwl_pkg::out_rsp_t                out_data
);

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int GW = ((IW > nwl_pkg::LA_W) ? IW : nwl_pkg::LA_W) + 1;

  nwl_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                    count_r, count_nxt, count_m1;
  logic [IW-1:0]                    last_idx;
  logic [IW-1:0]                    scan_idx_r, scan_idx_nxt;
  logic signed [nwl_pkg::POS_W-1:0] rob_x_r, rob_x_nxt, rob_y_r, rob_y_nxt;
  nwl_pkg::scan_tag_t               issue_tag, rd_tag_r;
  logic [IW-1:0]                    rd_idx_r;
  logic [nwl_pkg::DIST_W-1:0]       best_r, best_nxt;
  logic [IW-1:0]                    nearest_r, nearest_nxt;
  logic [IW-1:0]                    goal_r, goal_nxt;
  logic [GW-1:0]                    goal_sum;
  logic                             out_valid_r, out_valid_nxt;
  nwl_pkg::out_rsp_t                out_rsp_r, out_rsp_nxt;
  logic                             accept, is_query, empty_query;

  assign count_m1    = count_r - CW'(1);
  assign last_idx    = count_m1[IW-1:0];
  assign accept      = start && (state_r == nwl_pkg::ST_IDLE);
  assign is_query    = (in_data.mode == nwl_pkg::MODE_QUERY);
  assign empty_query = accept && is_query && (count_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nwl_pkg::ST_IDLE: begin
        if (accept && is_query && (count_r != '0)) begin
          state_nxt = nwl_pkg::ST_SCAN;
        end
      end
      nwl_pkg::ST_SCAN: begin
        if (scan_idx_r == last_idx) begin
          state_nxt = nwl_pkg::ST_DRAIN;
        end
      end
      nwl_pkg::ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = nwl_pkg::ST_GOAL;
        end
      end
      nwl_pkg::ST_GOAL: state_nxt = nwl_pkg::ST_READ;
      nwl_pkg::ST_READ: state_nxt = nwl_pkg::ST_RESP;
      nwl_pkg::ST_RESP: state_nxt = nwl_pkg::ST_IDLE;
      default:          state_nxt = nwl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy            = (state_r != nwl_pkg::ST_IDLE);
    wr_en           = accept && !is_query && (count_r < CW'(MAX_WAYPOINTS));
    wr_addr         = count_r[IW-1:0];
    wr_data.x       = in_data.pos_x;
    wr_data.y       = in_data.pos_y;
    wr_data.qx      = in_data.quat_x;
    wr_data.qy      = in_data.quat_y;
    wr_data.qz      = in_data.quat_z;
    wr_data.qw      = in_data.quat_w;
    rd_en           = (state_r == nwl_pkg::ST_SCAN) || (state_r == nwl_pkg::ST_READ);
    rd_addr         = (state_r == nwl_pkg::ST_READ) ? goal_r : scan_idx_r;
    issue_tag.vld   = (state_r == nwl_pkg::ST_SCAN);
    issue_tag.first = (scan_idx_r == '0);
    issue_tag.last  = (scan_idx_r == last_idx);
  end

  // datapath register updates
  always_comb begin
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    rob_x_nxt     = rob_x_r;
    rob_y_nxt     = rob_y_r;
    best_nxt      = best_r;
    nearest_nxt   = nearest_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    goal_sum = GW'(nearest_r) + GW'(lookahead);
    goal_nxt = (goal_sum > GW'(last_idx)) ? last_idx : goal_sum[IW-1:0];

    if (wr_en) begin
      count_nxt = count_r + CW'(1);
    end
    if (accept && is_query) begin
      rob_x_nxt    = in_data.pos_x;
      rob_y_nxt    = in_data.pos_y;
      scan_idx_nxt = '0;
    end
    if (state_r == nwl_pkg::ST_SCAN) begin
      scan_idx_nxt = scan_idx_r + IW'(1);
    end
    // strict less-than keeps the first entry on ties
    if (dist_tag.vld && (dist_tag.first || (dist_val < best_r))) begin
      best_nxt    = dist_val;
      nearest_nxt = dist_idx;
    end
    if (empty_query) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = '0;
    end
    if (state_r == nwl_pkg::ST_RESP) begin
      out_valid_nxt             = 1'b1;
      out_rsp_nxt.found         = 1'b1;
      out_rsp_nxt.nearest_index = nwl_pkg::IDX_OUT_W'(nearest_r);
      out_rsp_nxt.goal_index    = nwl_pkg::IDX_OUT_W'(goal_r);
      out_rsp_nxt.goal_x        = rd_data.x;
      out_rsp_nxt.goal_y        = rd_data.y;
      out_rsp_nxt.goal_qx       = rd_data.qx;
      out_rsp_nxt.goal_qy       = rd_data.qy;
      out_rsp_nxt.goal_qz       = rd_data.qz;
      out_rsp_nxt.goal_qw       = rd_data.qw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nwl_pkg::ST_IDLE;
      count_r     <= '0;
      rd_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_tag_r    <= issue_tag;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rob_x_r    <= rob_x_nxt;
    rob_y_r    <= rob_y_nxt;
    rd_idx_r   <= scan_idx_r;
    best_r     <= best_nxt;
    nearest_r  <= nearest_nxt;
    out_rsp_r  <= out_rsp_nxt;
    if (state_r == nwl_pkg::ST_GOAL) begin
      goal_r <= goal_nxt;
    end
  end

  assign rd_tag    = rd_tag_r;
  assign rd_idx    = rd_idx_r;
  assign rob_x     = rob_x_r;
  assign rob_y     = rob_y_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_rsp_r;

endmodule

FILE: tb/sv/nwl_tb_pkg.sv
`timescale 1ns / 1ps

package nwl_tb_pkg;

  import nwl_pkg::*;

  localparam int WP_DEPTH = 256;

  // Tracks the path table and lookahead and predicts the goal for each query.
  class goal_predictor;

    wp_t            path_wps [WP_DEPTH];
    int unsigned    wp_count;
    logic [LA_W-1:0] lookahead_val;
    out_rsp_t       expected_goals [$];
    int unsigned    mismatches;

    function new();
      wp_count      = 0;
      lookahead_val = LOOKAHEAD_RST;
      mismatches    = 0;
    endfunction

    function void set_lookahead(logic [LA_W-1:0] val);
      lookahead_val = val;
    endfunction

    function int unsigned pending();
      return expected_goals.size();
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t    goal;
      longint      best;
      longint      sq_dist;
      longint      dx;
      longint      dy;
      int unsigned near_i;
      int unsigned goal_i;
      if (req.mode == MODE_LOAD) begin
        // table full: the waypoint is dropped
        if (wp_count < WP_DEPTH) begin
          path_wps[wp_count] = wp_t'{x: req.pos_x, y: req.pos_y, qx: req.quat_x,
                                     qy: req.quat_y, qz: req.quat_z, qw: req.quat_w};
          wp_count++;
        end
        return;
      end
      goal = '0;
      if (wp_count != 0) begin
        best   = 0;
        near_i = 0;
        for (int unsigned i = 0; i < wp_count; i++) begin
          dx      = longint'(path_wps[i].x) - longint'(req.pos_x);
          dy      = longint'(path_wps[i].y) - longint'(req.pos_y);
          sq_dist = dx * dx + dy * dy;
          // strict less-than keeps the first entry on a tie
          if (i == 0 || sq_dist < best) begin
            best   = sq_dist;
            near_i = i;
          end
        end
        goal_i = near_i + lookahead_val;
        if (goal_i > wp_count - 1) begin
          goal_i = wp_count - 1;
        end
        goal.found         = 1'b1;
        goal.nearest_index = IDX_OUT_W'(near_i);
        goal.goal_index    = IDX_OUT_W'(goal_i);
        goal.goal_x        = path_wps[goal_i].x;
        goal.goal_y        = path_wps[goal_i].y;
        goal.goal_qx       = path_wps[goal_i].qx;
        goal.goal_qy       = path_wps[goal_i].qy;
        goal.goal_qz       = path_wps[goal_i].qz;
        goal.goal_qw       = path_wps[goal_i].qw;
      end
      expected_goals = {expected_goals, goal};
    endfunction

    function void compare_field(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_goal(out_rsp_t got);
      out_rsp_t want;
      if (expected_goals.size() == 0) begin
        $error("result with no query outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_goals.pop_front();
      compare_field("found", POS_W'(want.found), POS_W'(got.found));
      compare_field("nearest_index", POS_W'(want.nearest_index), POS_W'(got.nearest_index));
      compare_field("goal_index", POS_W'(want.goal_index), POS_W'(got.goal_index));
      compare_field("goal_x", want.goal_x, got.goal_x);
      compare_field("goal_y", want.goal_y, got.goal_y);
      compare_field("goal_qx", POS_W'(want.goal_qx), POS_W'(got.goal_qx));
      compare_field("goal_qy", POS_W'(want.goal_qy), POS_W'(got.goal_qy));
      compare_field("goal_qz", POS_W'(want.goal_qz), POS_W'(got.goal_qz));
      compare_field("goal_qw", POS_W'(want.goal_qw), POS_W'(got.goal_qw));
    endfunction

  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import nwl_pkg::*;
  import nwl_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_GAP     = 5;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  in_req_t         in_data   = '0;
  logic            out_valid;
  out_rsp_t        out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [LA_W-1:0] cfg_data  = '0;

  goal_predictor   tracker = new();
  int unsigned     cycle_count = 0;

  nearest_waypoint_lookahead #(
    .MAX_WAYPOINTS(WP_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** nearest_waypoint_lookahead: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.check_goal(out_data);
    end
  end

  // start is left high after a request so back-to-back requests need no gap
  task automatic send_request(input in_req_t req);
    int unsigned gap;
    gap = $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
  endtask

  task automatic write_lookahead(input logic [LA_W-1:0] val);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    // a load may still be settling
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_lookahead(val);
  endtask

  function automatic logic [POS_W-1:0] jitter(int span);
    return POS_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_req_t make_load();
    in_req_t     req;
    int unsigned n;
    n          = tracker.wp_count;
    req.mode   = MODE_LOAD;
    req.quat_x = QUAT_W'($urandom);
    req.quat_y = QUAT_W'($urandom);
    req.quat_z = QUAT_W'($urandom);
    req.quat_w = QUAT_W'($urandom);
    req.pos_x  = jitter(64);
    req.pos_y  = jitter(64);
    case ($urandom_range(0, 3))
      0: begin
        req.pos_x = POS_W'($urandom);
        req.pos_y = POS_W'($urandom);
      end
      2: begin
        // duplicate position of an earlier entry, makes distance ties
        if (n != 0) begin
          n         = $urandom_range(0, n - 1);
          req.pos_x = tracker.path_wps[n].x;
          req.pos_y = tracker.path_wps[n].y;
        end
      end
      3: begin
        // step along the path from the last entry
        if (n != 0 && n <= WP_DEPTH) begin
          req.pos_x = tracker.path_wps[n - 1].x + jitter(256);
          req.pos_y = tracker.path_wps[n - 1].y + jitter(256);
        end
      end
      default: ;
    endcase
    return req;
  endfunction

  function automatic in_req_t make_query();
    in_req_t     req;
    int unsigned n;
    n          = tracker.wp_count;
    req.mode   = MODE_QUERY;
    req.quat_x = QUAT_W'($urandom);
    req.quat_y = QUAT_W'($urandom);
    req.quat_z = QUAT_W'($urandom);
    req.quat_w = QUAT_W'($urandom);
    req.pos_x  = POS_W'($urandom);
    req.pos_y  = POS_W'($urandom);
    case ($urandom_range(0, 3))
      1: begin
        req.pos_x = jitter(64);
        req.pos_y = jitter(64);
      end
      2: begin
        if (n != 0) begin
          n         = $urandom_range(0, n - 1);
          req.pos_x = tracker.path_wps[n].x;
          req.pos_y = tracker.path_wps[n].y;
        end
      end
      3: begin
        if (n != 0) begin
          n         = $urandom_range(0, n - 1);
          req.pos_x = tracker.path_wps[n].x + jitter(512);
          req.pos_y = tracker.path_wps[n].y + jitter(512);
        end
      end
      default: ;
    endcase
    return req;
  endfunction

  initial begin
    logic [LA_W-1:0] phase_la [5];
    int unsigned     counted;
    bit              is_load;
    bit              full;

    phase_la = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd5};
    phase_la[3] = LA_W'($urandom_range(0, 255));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extreme positions, ties, clamp past the end
    send_request(in_req_t'{MODE_QUERY, 24'h7FFFFF, 24'h800000,
                           16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000});
    send_request(in_req_t'{MODE_LOAD, 24'h7FFFFF, 24'h800000,
                           16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF});
    send_request(in_req_t'{MODE_LOAD, 24'h800000, 24'h7FFFFF,
                           16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});
    send_request(in_req_t'{MODE_LOAD, 24'h000000, 24'h000000,
                           16'h4000, 16'h0000, 16'h0000, 16'h4000});
    send_request(in_req_t'{MODE_LOAD, 24'h000000, 24'h000000,
                           16'h0000, 16'h4000, 16'hC000, 16'h0001});
    send_request(in_req_t'{MODE_QUERY, 24'h7FFFFF, 24'h800000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_request(in_req_t'{MODE_QUERY, 24'h800000, 24'h7FFFFF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_request(in_req_t'{MODE_QUERY, 24'h000000, 24'h000000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_request(in_req_t'{MODE_QUERY, 24'h000100, 24'hFFFF00,
                           16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0});
    write_lookahead(8'd0);
    send_request(in_req_t'{MODE_QUERY, 24'h000000, 24'h000000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_request(in_req_t'{MODE_QUERY, 24'h7FFFFF, 24'h800000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    write_lookahead(8'd255);
    send_request(in_req_t'{MODE_QUERY, 24'h800000, 24'h7FFFFF,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_request(in_req_t'{MODE_LOAD, 24'h000001, 24'hFFFFFF,
                           16'h2AAA, 16'hD555, 16'h7FFF, 16'h8000});
    send_request(in_req_t'{MODE_QUERY, 24'h000001, 24'hFFFFFF,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    // equal distance to the first two entries from the far corner
    send_request(in_req_t'{MODE_QUERY, 24'h7FFFFF, 24'h7FFFFF,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});
    write_lookahead(8'd1);
    send_request(in_req_t'{MODE_QUERY, 24'h000000, 24'h000000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000});

    // random phases, one lookahead setting each; table fills along the way
    for (int p = 0; p < 5; p++) begin
      write_lookahead(phase_la[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        full    = (tracker.wp_count >= WP_DEPTH);
        is_load = full ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 1);
        // loads into a full table are dropped and do not count
        if (!is_load || !full) begin
          counted++;
        end
        if (is_load) begin
          send_request(make_load());
        end else begin
          send_request(make_query());
        end
      end
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("** nearest_waypoint_lookahead: PASSED **");
    end else begin
      $display("** nearest_waypoint_lookahead: FAILED **");
    end
    $finish;
  end

endmodule
